[rtl/core/abd_pkg.sv]
// Shared types and constants of the adaptive binary arithmetic decoder.
// Holds the command and state encodings and the parameter defaults.
// No dependencies.
package abd_pkg;

	localparam int unsigned NUM_CONTEXTS_DEF    = 256;
	localparam int unsigned PROB_SHIFT_DEF      = 13;
	localparam int unsigned MAX_TOTAL_DEF       = 8192;
	localparam int unsigned MIN_LENGTH_LOG2_DEF = 24;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned CMD_W       = 2;
	localparam int unsigned CTX_REQ_W   = 8;
	localparam int unsigned USED_W      = 3;
	localparam int unsigned PERIOD_W    = 7;
	localparam int unsigned PERIOD_INIT = 4;
	localparam int unsigned PERIOD_CAP  = 64;
	localparam int unsigned RECIP_W     = 32;

	localparam logic [WORD_W-1:0] FULL_LENGTH = 32'hFFFF_FFFF;
	localparam logic [USED_W-1:0] BYTES_LOAD  = 3'd4;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT    = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_DECODE  = 2'd2,
		CMD_RESET   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_DEC,
		ST_ADJ,
		ST_DIV,
		ST_PROB,
		ST_WB
	} state_t;

endpackage

[rtl/core/abd_req_if.sv]
// Request channel of the decoder: command, context and lookahead window.
// Depends on abd_pkg for the field widths.
interface abd_req_if import abd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     cmd;
	logic [CTX_REQ_W-1:0] context_req;
	logic [WORD_W-1:0]    window;

	modport source (output valid, output cmd, output context_req, output window, input ready);
	modport sink (input valid, input cmd, input context_req, input window, output ready);
endinterface

[rtl/core/abd_res_if.sv]
// Result channel of the decoder: decoded bit and stream bytes consumed.
// Depends on abd_pkg for the field widths.
interface abd_res_if import abd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              bit_res;
	logic [USED_W-1:0] bytes_used;

	modport source (output valid, output bit_res, output bytes_used, input ready);
	modport sink (input valid, input bit_res, input bytes_used, output ready);
endinterface

[rtl/core/abd_model_mem.sv]
// Context model memory: one write port, one read port with registered data.
// Depends on abd_pkg for its default depth.
module abd_model_mem import abd_pkg::*; #(
	parameter int unsigned DEPTH  = NUM_CONTEXTS_DEF,
	parameter int unsigned ADDR_W = 8,
	parameter int unsigned DATA_W = 55
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/abd_recip_div.sv]
// Radix-2 restoring divider computing 2^31 / divisor, one quotient bit per cycle.
// Depends on abd_pkg for the quotient width.
module abd_recip_div import abd_pkg::*; #(
	parameter int unsigned DIV_W = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_W-1:0]   divisor,
	output logic               done,
	output logic [RECIP_W-1:0] quot
);

	localparam int unsigned CNT_W = $clog2(RECIP_W);
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(RECIP_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W-1:0] rem_q;
	logic [RECIP_W-1:0] quot_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, cnt_q == CNT_TOP};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_TOP;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quot_q <= {quot_q[RECIP_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q == '0 && !start |=> done_q)
		else $error("divider finished without done");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");

endmodule

[rtl/core/adaptive_binary_arith_decoder_top.sv]
// Adaptive binary arithmetic decoder, top level.
// Depends on abd_pkg, abd_req_if, abd_res_if, abd_model_mem and abd_recip_div.
//
// Requests arrive on req (cmd, context_req, window); one result per request
// leaves on res (bit_res, bytes_used). Both are valid/ready channels.
// After reset the model memory is swept, one context per cycle; req.ready
// stays low during the sweep.
// Each request passes model read (issued in its acceptance cycle), probability
// multiply, and compare and renormalize with write-back before the next
// can be accepted.
// A decode that ends an adaptation period adds count adjust, the reciprocal
// divide (32 quotient bits), probability multiply and write-back.
// The result sits in an output register, so a stalled receiver does not
// hold the decoder until the next result is ready; the decoder then waits
// in its compare stage until the register is taken.
// One request is in flight at a time; the model memory read-modify-write
// is thus never overlapped.
module adaptive_binary_arith_decoder_top import abd_pkg::*; #(
	parameter int unsigned NUM_CONTEXTS    = NUM_CONTEXTS_DEF,
	parameter int unsigned PROB_SHIFT      = PROB_SHIFT_DEF,
	parameter int unsigned MAX_TOTAL       = MAX_TOTAL_DEF,
	parameter int unsigned MIN_LENGTH_LOG2 = MIN_LENGTH_LOG2_DEF
) (
	input logic clk,
	input logic arst_n,
	abd_req_if.sink   req,
	abd_res_if.source res
);

	localparam int unsigned CTX_W    = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int unsigned CTX_SPAN = 1 << CTX_REQ_W;
	localparam int unsigned COUNT_W  = $clog2(MAX_TOTAL + PERIOD_CAP + 1);
	localparam int unsigned PER_LSB  = PERIOD_W;
	localparam int unsigned PROB_LSB = 2 * PERIOD_W;
	localparam int unsigned TOT_LSB  = PROB_LSB + PROB_SHIFT;
	localparam int unsigned ZC_LSB   = TOT_LSB + COUNT_W;
	localparam int unsigned ENT_W    = ZC_LSB + COUNT_W;

	localparam logic [CTX_W-1:0]    LAST_CTX   = CTX_W'(NUM_CONTEXTS - 1);
	localparam logic [WORD_W-1:0]   MIN_LENGTH = WORD_W'(64'd1 << MIN_LENGTH_LOG2);
	localparam logic [PROB_SHIFT-1:0] PROB_HALF = PROB_SHIFT'(1) << (PROB_SHIFT - 1);
	localparam logic [ENT_W-1:0] RESET_ENT = {COUNT_W'(1), COUNT_W'(2), PROB_HALF,
		PERIOD_W'(PERIOD_INIT), PERIOD_W'(PERIOD_INIT)};

	state_t state_q, state_d;

	logic                 accept;
	logic                 dec_go;
	logic [CTX_W-1:0]     ctx_tbl [CTX_SPAN];
	logic [CTX_W-1:0]     ctx_idx;
	logic [CTX_W-1:0]     clr_cnt_q;

	cmd_t                 cmd_q;
	logic [CTX_W-1:0]     ctx_q;
	logic [WORD_W-1:0]    win_q;
	logic [WORD_W-1:0]    code_q;
	logic [WORD_W-1:0]    len_q;
	logic [WORD_W-1:0]    x_s1;
	logic [WORD_W-1:0]    prod_s1;
	logic [COUNT_W-1:0]   ad_zc_q;
	logic [COUNT_W-1:0]   ad_tot_q;
	logic [PERIOD_W-1:0]  ad_per_q;
	logic                 out_valid_q;
	logic                 out_bit_q;
	logic [USED_W-1:0]    out_used_q;

	logic                 mem_we;
	logic                 mem_re;
	logic [CTX_W-1:0]     mem_waddr;
	logic [ENT_W-1:0]     mem_wdata;
	logic [ENT_W-1:0]     mem_rdata;

	logic                 div_start;
	logic                 div_done;
	logic [COUNT_W-1:0]   div_divisor;
	logic [RECIP_W-1:0]   div_quot;

	logic [COUNT_W-1:0]    ent_zc;
	logic [COUNT_W-1:0]    ent_tot;
	logic [PROB_SHIFT-1:0] ent_prob;
	logic [PERIOD_W-1:0]   ent_per;
	logic [PERIOD_W-1:0]   ent_bta;

	logic                 dec_bit;
	logic [WORD_W-1:0]    len_a;
	logic [WORD_W-1:0]    code_a;
	logic [WORD_W-1:0]    len_sh1;
	logic [WORD_W-1:0]    len_sh2;
	logic [WORD_W-1:0]    len_sh3;
	logic [USED_W-1:0]    norm_n;
	logic [WORD_W-1:0]    code_n;
	logic [WORD_W-1:0]    len_n;
	logic [COUNT_W-1:0]   zc_inc;
	logic [PERIOD_W-1:0]  bta_dec;
	logic                 adapt_due;

	logic [COUNT_W:0]     ad_sum;
	logic [COUNT_W:0]     sum_p1;
	logic [COUNT_W:0]     zc_p1;
	logic [COUNT_W-1:0]   h_tot;
	logic [COUNT_W-1:0]   h_zc;
	logic [COUNT_W-1:0]   h_tot_fix;
	logic                 ad_over;
	logic [COUNT_W-1:0]   tot_adj;
	logic [COUNT_W-1:0]   zc_adj;

	logic [PROB_SHIFT-1:0] prob_new;
	logic [PERIOD_W+2:0]  per5;
	logic [PERIOD_W:0]    per_sh;
	logic [PERIOD_W-1:0]  per_new;

	for (genvar gi = 0; gi < CTX_SPAN; gi++) begin : g_ctx
		localparam int unsigned CtxMod = gi % NUM_CONTEXTS;
		assign ctx_tbl[gi] = CTX_W'(CtxMod);
	end

	assign ctx_idx = ctx_tbl[req.context_req];
	assign accept  = req.valid && req.ready;
	assign dec_go  = (state_q == ST_DEC) && (!out_valid_q || res.ready);

	abd_model_mem #(
		.DEPTH  (NUM_CONTEXTS),
		.ADDR_W (CTX_W),
		.DATA_W (ENT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (ctx_idx),
		.rdata (mem_rdata)
	);

	abd_recip_div #(
		.DIV_W (COUNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (div_divisor),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign ent_zc   = mem_rdata[ZC_LSB +: COUNT_W];
	assign ent_tot  = mem_rdata[TOT_LSB +: COUNT_W];
	assign ent_prob = mem_rdata[PROB_LSB +: PROB_SHIFT];
	assign ent_per  = mem_rdata[PER_LSB +: PERIOD_W];
	assign ent_bta  = mem_rdata[PERIOD_W-1:0];

	// interval update and byte renormalization
	always_comb begin
		dec_bit = code_q >= x_s1;
		len_a   = dec_bit ? (len_q - x_s1) : x_s1;
		code_a  = dec_bit ? (code_q - x_s1) : code_q;
		len_sh1 = {len_a[23:0], 8'h00};
		len_sh2 = {len_a[15:0], 16'h0000};
		len_sh3 = {len_a[7:0], 24'h000000};
		if (len_a >= MIN_LENGTH) begin
			norm_n = 3'd0;
		end else if (len_sh1 >= MIN_LENGTH) begin
			norm_n = 3'd1;
		end else if (len_sh2 >= MIN_LENGTH) begin
			norm_n = 3'd2;
		end else if (len_sh3 >= MIN_LENGTH) begin
			norm_n = 3'd3;
		end else begin
			norm_n = 3'd4;
		end
		case (norm_n)
			3'd0: begin
				code_n = code_a;
				len_n  = len_a;
			end
			3'd1: begin
				code_n = {code_a[23:0], win_q[31:24]};
				len_n  = len_sh1;
			end
			3'd2: begin
				code_n = {code_a[15:0], win_q[31:16]};
				len_n  = len_sh2;
			end
			3'd3: begin
				code_n = {code_a[7:0], win_q[31:8]};
				len_n  = len_sh3;
			end
			default: begin
				code_n = win_q;
				len_n  = '0;
			end
		endcase
		zc_inc    = dec_bit ? ent_zc : (ent_zc + COUNT_W'(1));
		bta_dec   = ent_bta - PERIOD_W'(1);
		adapt_due = (cmd_q == CMD_DECODE) && (bta_dec == '0);
	end

	// count adjustment ahead of the probability rebuild
	always_comb begin
		ad_sum    = {1'b0, ad_tot_q} + (COUNT_W+1)'(ad_per_q);
		sum_p1    = ad_sum + (COUNT_W+1)'(1);
		zc_p1     = {1'b0, ad_zc_q} + (COUNT_W+1)'(1);
		h_tot     = sum_p1[COUNT_W:1];
		h_zc      = zc_p1[COUNT_W:1];
		h_tot_fix = (h_zc == h_tot) ? (h_tot + COUNT_W'(1)) : h_tot;
		ad_over   = ad_sum > (COUNT_W+1)'(MAX_TOTAL);
		tot_adj   = ad_over ? h_tot_fix : ad_sum[COUNT_W-1:0];
		zc_adj    = ad_over ? h_zc : ad_zc_q;
		div_divisor = (tot_adj == '0) ? COUNT_W'(1) : tot_adj;
	end

	always_comb begin
		prob_new = prod_s1[WORD_W-2 -: PROB_SHIFT];
		per5     = ((PERIOD_W+3)'(ad_per_q) << 2) + (PERIOD_W+3)'(ad_per_q);
		per_sh   = per5[PERIOD_W+2:2];
		per_new  = (per_sh > (PERIOD_W+1)'(PERIOD_CAP)) ? PERIOD_W'(PERIOD_CAP)
			: per_sh[PERIOD_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_CTX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DEC;
			end
			ST_DEC: begin
				if (dec_go) begin
					state_d = adapt_due ? ST_ADJ : ST_IDLE;
				end
			end
			ST_ADJ: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_PROB;
				end
			end
			ST_PROB: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ctx_q;
		mem_wdata = RESET_ENT;
		div_start = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				mem_re    = req.valid;
			end
			ST_DEC: begin
				if (dec_go && cmd_q == CMD_RESET) begin
					mem_we = 1'b1;
				end else if (dec_go && cmd_q == CMD_DECODE && !adapt_due) begin
					mem_we    = 1'b1;
					mem_wdata = {zc_inc, ent_tot, ent_prob, ent_per, bta_dec};
				end
			end
			ST_ADJ: begin
				div_start = 1'b1;
			end
			ST_WB: begin
				mem_we    = 1'b1;
				mem_wdata = {ad_zc_q, ad_tot_q, prob_new, per_new, per_new};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			code_q      <= '0;
			len_q       <= FULL_LENGTH;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + CTX_W'(1);
			end
			if (dec_go) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (dec_go) begin
				case (cmd_q)
					CMD_INIT: begin
						len_q  <= FULL_LENGTH;
						code_q <= win_q;
					end
					CMD_RESTART: begin
						len_q <= FULL_LENGTH;
					end
					CMD_DECODE: begin
						len_q  <= len_n;
						code_q <= code_n;
					end
					default: begin
						len_q <= len_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(req.cmd);
			ctx_q <= ctx_idx;
			win_q <= req.window;
		end
		if (state_q == ST_MUL) begin
			x_s1 <= WORD_W'(ent_prob) * WORD_W'(len_q[WORD_W-1:PROB_SHIFT]);
		end
		if (dec_go) begin
			out_bit_q  <= (cmd_q == CMD_DECODE) && dec_bit;
			out_used_q <= (cmd_q == CMD_DECODE) ? norm_n
				: ((cmd_q == CMD_INIT) ? BYTES_LOAD : '0);
			ad_zc_q    <= zc_inc;
			ad_tot_q   <= ent_tot;
			ad_per_q   <= ent_per;
		end
		if (state_q == ST_ADJ) begin
			ad_zc_q  <= zc_adj;
			ad_tot_q <= tot_adj;
		end
		if (state_q == ST_PROB) begin
			prod_s1 <= WORD_W'(ad_zc_q) * div_quot;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.bit_res    = out_bit_q;
	assign res.bytes_used = out_used_q;

	a_mem_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("model memory read and write in one cycle");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider result outside of divide state");
	a_result_issued: assert property (@(posedge clk) disable iff (!arst_n)
		dec_go |=> res.valid)
		else $error("result not registered");
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.bytes_used <= BYTES_LOAD)
		else $error("byte count out of range");

endmodule
